// ===== rtl/owtr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owtr_pkg
// Shared constants, types and helpers of the 1-Wire temperature reader.
// ----------------------------------------------------------------------------
package owtr_pkg;

    localparam int TIMER_BITS = 16;
    localparam int MAG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int UNITS_W    = 10;
    localparam int TPU_W      = 8;
    localparam int PROD_W     = UNITS_W + TPU_W;
    localparam int WIDE_W     = (TIMER_BITS > PROD_W) ? TIMER_BITS : PROD_W;
    localparam int PHASE_W    = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_UNIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_RELEASE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_SLOT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_READ_RECOVERY  = 3'd5;

    // bus sequencer phases
    localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_RST_LOW = 4'd1;
    localparam logic [PHASE_W-1:0] PH_RST_REL = 4'd2;
    localparam logic [PHASE_W-1:0] PH_PRES_HI = 4'd3;
    localparam logic [PHASE_W-1:0] PH_PRES_LO = 4'd4;
    localparam logic [PHASE_W-1:0] PH_WR_LOW  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_WR_REL  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_RD_LOW  = 4'd7;
    localparam logic [PHASE_W-1:0] PH_RD_SAMP = 4'd8;
    localparam logic [PHASE_W-1:0] PH_RD_REC  = 4'd9;

    // bus commands
    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_PAD = 8'hBE;

    localparam logic [UNITS_W-1:0] SHORT_UNITS = 10'd2;
    localparam logic [UNITS_W-1:0] ONE_UNIT    = 10'd1;
    localparam logic [4:0]         NEG_MASK    = 5'h1F;

    typedef logic [TIMER_BITS-1:0] t_ticks;

    typedef struct packed {
        t_ticks     rst_low;
        t_ticks     rst_rel;
        t_ticks     unit_m1;
        t_ticks     slot_short;
        t_ticks     slot_long;
        t_ticks     rec;
        logic [7:0] poll_limit;
    } t_timing;

    typedef struct packed {
        logic             drive_low;
        logic             busy_res;
        logic             done_res;
        logic             presence_error;
        logic             temp_negative;
        logic [MAG_W-1:0] temp_magnitude;
    } t_result;

    function automatic logic [7:0] cmd_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = CMD_SKIP_ROM;
            2'd1:    b = CMD_CONVERT;
            2'd2:    b = CMD_SKIP_ROM;
            default: b = CMD_READ_PAD;
        endcase
        return b;
    endfunction

    // units times ticks per unit, saturated, never below one tick
    function automatic t_ticks dur(input logic [UNITS_W-1:0] units,
                                   input logic [TPU_W-1:0] tpu);
        logic [PROD_W-1:0] p;
        logic [WIDE_W-1:0] pw;
        logic [WIDE_W-1:0] cap;
        t_ticks            res;
        p   = PROD_W'(units) * PROD_W'(tpu);
        pw  = WIDE_W'(p);
        cap = WIDE_W'({TIMER_BITS{1'b1}});
        if (pw > cap) begin
            res = '1;
        end else begin
            res = TIMER_BITS'(pw);
        end
        if (res == '0) begin
            res = TIMER_BITS'(1);
        end
        return res;
    endfunction

endpackage

// ===== rtl/owtr_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owtr_in_if
// Input channel: one item per timebase tick with start request and line level.
// ----------------------------------------------------------------------------
interface owtr_in_if;
    logic valid;
    logic ready;
    logic start_request;
    logic line_level;

    modport source (output valid, output start_request, output line_level, input ready);
    modport sink   (input valid, input start_request, input line_level, output ready);
endinterface

// ===== rtl/owtr_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owtr_out_if
// Result channel: bus drive, status flags and the temperature result.
// ----------------------------------------------------------------------------
interface owtr_out_if;
    import owtr_pkg::*;
    logic             valid;
    logic             ready;
    logic             drive_low;
    logic             busy_res;
    logic             done_res;
    logic             presence_error;
    logic             temp_negative;
    logic [MAG_W-1:0] temp_magnitude;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output presence_error, output temp_negative, output temp_magnitude,
                    input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input presence_error, input temp_negative, input temp_magnitude,
                    output ready);
endinterface

// ===== rtl/owtr_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owtr_cfg
// Configuration registers and the registered slot durations in ticks.
// ----------------------------------------------------------------------------
module owtr_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [owtr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [owtr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output owtr_pkg::t_timing                 o_timing
);
    import owtr_pkg::*;

    logic [7:0] r_tpu;
    logic [9:0] r_rst_low;
    logic [7:0] r_rst_rel;
    logic [7:0] r_poll_limit;
    logic [7:0] r_slot;
    logic [7:0] r_rec;
    t_timing    r_timing;
    t_timing    n_timing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpu        <= 8'd1;
            r_rst_low    <= 10'd75;
            r_rst_rel    <= 8'd2;
            r_poll_limit <= 8'd20;
            r_slot       <= 8'd6;
            r_rec        <= 8'd5;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TICKS_PER_UNIT: r_tpu        <= i_cfg_data[7:0];
                REG_RESET_LOW:      r_rst_low    <= i_cfg_data;
                REG_RESET_RELEASE:  r_rst_rel    <= i_cfg_data[7:0];
                REG_POLL_LIMIT:     r_poll_limit <= i_cfg_data[7:0];
                REG_WRITE_SLOT:     r_slot       <= i_cfg_data[7:0];
                REG_READ_RECOVERY:  r_rec        <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_timing.rst_low    = dur(r_rst_low, r_tpu);
        n_timing.rst_rel    = dur(UNITS_W'(r_rst_rel), r_tpu);
        n_timing.unit_m1    = dur(ONE_UNIT, r_tpu) - TIMER_BITS'(1);
        n_timing.slot_short = dur(SHORT_UNITS, r_tpu);
        n_timing.slot_long  = dur(UNITS_W'(r_slot), r_tpu);
        n_timing.rec        = dur(UNITS_W'(r_rec), r_tpu);
        n_timing.poll_limit = r_poll_limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.rst_low    <= TIMER_BITS'(75);
            r_timing.rst_rel    <= TIMER_BITS'(2);
            r_timing.unit_m1    <= '0;
            r_timing.slot_short <= TIMER_BITS'(2);
            r_timing.slot_long  <= TIMER_BITS'(6);
            r_timing.rec        <= TIMER_BITS'(5);
            r_timing.poll_limit <= 8'd20;
        end else begin
            r_timing <= n_timing;
        end
    end

    assign o_timing = r_timing;

endmodule

// ===== rtl/owtr_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owtr_core
// Bus sequencer state and the per-tick step: reset, presence, command
// writes, scratchpad read and result conversion.
// ----------------------------------------------------------------------------
module owtr_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_start,
    input  logic                i_line,
    input  owtr_pkg::t_timing   i_timing,
    output owtr_pkg::t_result   o_result
);
    import owtr_pkg::*;

    logic [PHASE_W-1:0] r_phase, n_phase;
    t_ticks             r_tc, n_tc;
    logic [7:0]         r_poll, n_poll;
    logic [2:0]         r_bit, n_bit;
    logic [1:0]         r_byte, n_byte;
    logic [7:0]         r_shift, n_shift;
    logic [7:0]         r_low, n_low;
    logic               r_err, n_err;
    logic               r_sign, n_sign;
    logic [MAG_W-1:0]   r_val, n_val;

    logic [PHASE_W-1:0] ph;
    t_ticks             tc;
    t_ticks             tcd;
    logic               drive;
    logic               busy;
    logic               done;
    logic [1:0]         wb_idx;
    logic [7:0]         wb_cmd;
    t_ticks             wb_tc;
    logic [2:0]         bit_inc;
    logic [7:0]         shift_dn;
    logic [15:0]        raw;

    always_comb begin
        n_phase = r_phase;
        n_tc    = r_tc;
        n_poll  = r_poll;
        n_bit   = r_bit;
        n_byte  = r_byte;
        n_shift = r_shift;
        n_low   = r_low;
        n_err   = r_err;
        n_sign  = r_sign;
        n_val   = r_val;
        drive   = 1'b0;
        busy    = 1'b1;
        done    = 1'b0;

        ph = (r_phase > PH_RD_REC) ? PH_IDLE : r_phase;
        tc = r_tc;
        if (ph == PH_IDLE && i_start) begin
            n_err  = 1'b0;
            n_byte = 2'd0;
            n_bit  = 3'd0;
            ph     = PH_RST_LOW;
            tc     = i_timing.rst_low;
        end
        tcd = (tc != '0) ? tc - TIMER_BITS'(1) : '0;
        n_phase = ph;
        n_tc    = tc;

        // next command byte and its first bit
        wb_idx   = (ph == PH_WR_REL) ? r_byte + 2'd1 : r_byte;
        wb_cmd   = cmd_byte(wb_idx);
        wb_tc    = wb_cmd[0] ? i_timing.slot_short : i_timing.slot_long;
        bit_inc  = r_bit + 3'd1;
        shift_dn = {1'b0, r_shift[7:1]};
        raw      = {r_shift, r_low};

        case (ph)
            PH_RST_LOW: begin
                drive = 1'b1;
                if (tcd == '0) begin
                    n_phase = PH_RST_REL;
                    n_tc    = i_timing.rst_rel;
                end else begin
                    n_tc = tcd;
                end
            end
            PH_RST_REL: begin
                if (tcd == '0) begin
                    n_phase = PH_PRES_HI;
                    n_tc    = '0;
                    n_poll  = 8'd0;
                end else begin
                    n_tc = tcd;
                end
            end
            PH_PRES_HI: begin
                if (tc != '0) begin
                    n_tc = tcd;
                end else if (r_poll >= i_timing.poll_limit) begin
                    n_err   = 1'b1;
                    n_shift = wb_cmd;
                    n_bit   = 3'd0;
                    n_phase = PH_WR_LOW;
                    n_tc    = wb_tc;
                end else if (i_line) begin
                    n_poll = r_poll + 8'd1;
                    n_tc   = i_timing.unit_m1;
                end else if (i_timing.poll_limit == 8'd0) begin
                    n_poll  = 8'd0;
                    n_err   = 1'b1;
                    n_shift = wb_cmd;
                    n_bit   = 3'd0;
                    n_phase = PH_WR_LOW;
                    n_tc    = wb_tc;
                end else begin
                    n_phase = PH_PRES_LO;
                    n_poll  = 8'd1;
                    n_tc    = i_timing.unit_m1;
                end
            end
            PH_PRES_LO: begin
                if (tc != '0) begin
                    n_tc = tcd;
                end else if (r_poll >= i_timing.poll_limit || i_line) begin
                    if (r_poll >= i_timing.poll_limit) begin
                        n_err = 1'b1;
                    end
                    n_shift = wb_cmd;
                    n_bit   = 3'd0;
                    n_phase = PH_WR_LOW;
                    n_tc    = wb_tc;
                end else begin
                    n_poll = r_poll + 8'd1;
                    n_tc   = i_timing.unit_m1;
                end
            end
            PH_WR_LOW: begin
                drive = 1'b1;
                if (tcd == '0) begin
                    n_phase = PH_WR_REL;
                    n_tc    = r_shift[0] ? i_timing.slot_long : i_timing.slot_short;
                end else begin
                    n_tc = tcd;
                end
            end
            PH_WR_REL: begin
                if (tcd != '0) begin
                    n_tc = tcd;
                end else if (bit_inc != 3'd0) begin
                    n_shift = shift_dn;
                    n_bit   = bit_inc;
                    n_phase = PH_WR_LOW;
                    n_tc    = shift_dn[0] ? i_timing.slot_short : i_timing.slot_long;
                end else if (r_byte == 2'd1) begin
                    n_shift = shift_dn;
                    n_bit   = bit_inc;
                    n_byte  = 2'd2;
                    n_phase = PH_RST_LOW;
                    n_tc    = i_timing.rst_low;
                end else if (r_byte == 2'd3) begin
                    n_bit   = bit_inc;
                    n_byte  = 2'd0;
                    n_shift = 8'd0;
                    n_phase = PH_RD_LOW;
                    n_tc    = i_timing.slot_short;
                end else begin
                    n_byte  = wb_idx;
                    n_shift = wb_cmd;
                    n_bit   = 3'd0;
                    n_phase = PH_WR_LOW;
                    n_tc    = wb_tc;
                end
            end
            PH_RD_LOW: begin
                drive = 1'b1;
                if (tcd == '0) begin
                    n_phase = PH_RD_SAMP;
                    n_tc    = TIMER_BITS'(1);
                end else begin
                    n_tc = tcd;
                end
            end
            PH_RD_SAMP: begin
                n_shift = {i_line, r_shift[7:1]};
                n_phase = PH_RD_REC;
                n_tc    = i_timing.rec;
            end
            PH_RD_REC: begin
                if (tcd != '0) begin
                    n_tc = tcd;
                end else if (bit_inc != 3'd0) begin
                    n_bit   = bit_inc;
                    n_phase = PH_RD_LOW;
                    n_tc    = i_timing.slot_short;
                end else if (r_byte == 2'd0) begin
                    n_bit   = bit_inc;
                    n_low   = r_shift;
                    n_byte  = 2'd1;
                    n_shift = 8'd0;
                    n_phase = PH_RD_LOW;
                    n_tc    = i_timing.slot_short;
                end else begin
                    n_bit   = bit_inc;
                    n_tc    = '0;
                    if (raw[15:11] == NEG_MASK) begin
                        n_sign = 1'b1;
                        n_val  = MAG_W'(~raw + 16'd1);
                    end else begin
                        n_sign = 1'b0;
                        n_val  = MAG_W'(raw);
                    end
                    done    = 1'b1;
                    n_byte  = 2'd0;
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tc    <= '0;
            r_poll  <= '0;
            r_bit   <= '0;
            r_byte  <= '0;
            r_shift <= '0;
            r_low   <= '0;
            r_err   <= 1'b0;
            r_sign  <= 1'b0;
            r_val   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tc    <= n_tc;
            r_poll  <= n_poll;
            r_bit   <= n_bit;
            r_byte  <= n_byte;
            r_shift <= n_shift;
            r_low   <= n_low;
            r_err   <= n_err;
            r_sign  <= n_sign;
            r_val   <= n_val;
        end
    end

    assign o_result.drive_low      = drive;
    assign o_result.busy_res       = busy;
    assign o_result.done_res       = done;
    assign o_result.presence_error = n_err;
    assign o_result.temp_negative  = n_sign;
    assign o_result.temp_magnitude = n_val;

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && done |-> busy)
        else $error("done without busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && done |=> r_phase == PH_IDLE && r_byte == 2'd0)
        else $error("sequencer not idle after done");

    a_idle_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_bit == 3'd0 && r_byte == 2'd0)
        else $error("bit or byte count left over in idle");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_tc) && $stable(r_val))
        else $error("state moved without an item");

endmodule

// ===== rtl/one_wire_temp_reader_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_temp_reader_top
// 1-Wire master that reads a temperature sensor, one item per timebase tick.
// ----------------------------------------------------------------------------
// path: input item through the input register, then the result register;
//   one result item for every input item
// throughput: one item per cycle unless a held result waits for ready
// reset: synchronous, active low; sequencer idle, result valid low, registers
//   at their defaults; configuration acts after the cfg and timing registers
module one_wire_temp_reader_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [owtr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [owtr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    owtr_in_if.sink                         i_item,
    owtr_out_if.source                      o_result
);
    import owtr_pkg::*;

    t_timing timing;
    t_result step_res;
    t_result r_out;
    logic    r_in_valid;
    logic    r_in_start;
    logic    r_in_line;
    logic    r_out_valid;
    logic    step_go;
    logic    in_ready;

    assign step_go  = r_in_valid && (!r_out_valid || o_result.ready);
    assign in_ready = !r_in_valid || step_go;

    owtr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_timing   (timing)
    );

    owtr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step_go),
        .i_start  (r_in_start),
        .i_line   (r_in_line),
        .i_timing (timing),
        .o_result (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_item.valid) begin
            r_in_start <= i_item.start_request;
            r_in_line  <= i_item.line_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_go) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_out <= step_res;
        end
    end

    assign i_item.ready            = in_ready;
    assign o_result.valid          = r_out_valid;
    assign o_result.drive_low      = r_out.drive_low;
    assign o_result.busy_res       = r_out.busy_res;
    assign o_result.done_res       = r_out.done_res;
    assign o_result.presence_error = r_out.presence_error;
    assign o_result.temp_negative  = r_out.temp_negative;
    assign o_result.temp_magnitude = r_out.temp_magnitude;

endmodule

// ===== sim/one_wire_temp_reader_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_temp_reader_top_tb
// Self-checking bench for the 1-Wire temperature reader. An emulated sensor
// answers the reset pulses and read slots from the predicted bus state, and
// every result item is compared with a cycle-exact model of the sequencer.
// Timing registers run at their defaults, at minimum and at zero values, and
// both channels see random gaps plus one long result stall.
// ----------------------------------------------------------------------------
module one_wire_temp_reader_top_tb;
    import owtr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
    localparam int                   LONG_HOLD     = 400;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    owtr_in_if  item_if();
    owtr_out_if result_if();

    one_wire_temp_reader_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (item_if),
        .o_result   (result_if)
    );

    // timing registers as the bench expects them
    logic [7:0] tpu_cfg;
    logic [9:0] rst_low_cfg;
    logic [7:0] rst_rel_cfg;
    logic [7:0] poll_lim_cfg;
    logic [7:0] slot_cfg;
    logic [7:0] rec_cfg;

    // sequencer state
    logic [PHASE_W-1:0] seq_phase;
    logic [15:0]        tick_cnt;
    logic [7:0]         poll_cnt;
    logic [2:0]         bit_idx;
    logic [1:0]         byte_idx;
    logic [7:0]         shreg;
    logic [7:0]         lsb_byte;
    logic               err_flag;
    logic               temp_sign;
    logic [15:0]        temp_mag;

    t_result pending_status[$];
    int      fail_count;
    bit      long_hold_req;

    always #1 i_clk = ~i_clk;

    function automatic logic [15:0] timed_ticks(input logic [9:0] units);
        int unsigned prod;
        prod = units * tpu_cfg;
        if (prod > 32'hFFFF) prod = 32'hFFFF;
        if (prod == 0) prod = 1;
        return prod[15:0];
    endfunction

    function automatic logic count_down();
        if (tick_cnt != 0) tick_cnt = tick_cnt - 16'd1;
        return tick_cnt == 0;
    endfunction

    function automatic logic [7:0] command_at(input logic [1:0] n);
        case (n)
            2'd1:    return CMD_CONVERT;
            2'd3:    return CMD_READ_PAD;
            default: return CMD_SKIP_ROM;
        endcase
    endfunction

    function automatic void start_reset();
        seq_phase = PH_RST_LOW;
        tick_cnt  = timed_ticks(rst_low_cfg);
    endfunction

    function automatic void start_write_bit();
        seq_phase = PH_WR_LOW;
        tick_cnt  = timed_ticks(shreg[0] ? SHORT_UNITS : 10'(slot_cfg));
    endfunction

    function automatic void start_write_byte();
        shreg   = command_at(byte_idx);
        bit_idx = 3'd0;
        start_write_bit();
    endfunction

    function automatic void start_read_bit();
        seq_phase = PH_RD_LOW;
        tick_cnt  = timed_ticks(SHORT_UNITS);
    endfunction

    function automatic void presence_low(input logic line);
        if (poll_cnt >= poll_lim_cfg) begin
            err_flag = 1'b1;
            start_write_byte();
        end else if (!line) begin
            poll_cnt = poll_cnt + 8'd1;
            tick_cnt = timed_ticks(ONE_UNIT) - 16'd1;
        end else begin
            start_write_byte();
        end
    endfunction

    function automatic void clear_state();
        tpu_cfg      = 8'd1;
        rst_low_cfg  = 10'd75;
        rst_rel_cfg  = 8'd2;
        poll_lim_cfg = 8'd20;
        slot_cfg     = 8'd6;
        rec_cfg      = 8'd5;
        seq_phase    = PH_IDLE;
        tick_cnt     = '0;
        poll_cnt     = '0;
        bit_idx      = '0;
        byte_idx     = '0;
        shreg        = '0;
        lsb_byte     = '0;
        err_flag     = 1'b0;
        temp_sign    = 1'b0;
        temp_mag     = '0;
    endfunction

    // one timebase tick of the bus sequencer
    function automatic t_result predict_tick(input logic start, input logic line);
        logic        drv;
        logic        busy;
        logic        done;
        logic [15:0] raw;
        drv  = 1'b0;
        busy = 1'b1;
        done = 1'b0;
        if (seq_phase == PH_IDLE && start) begin
            err_flag = 1'b0;
            byte_idx = 2'd0;
            bit_idx  = 3'd0;
            start_reset();
        end
        case (seq_phase)
            PH_RST_LOW: begin
                drv = 1'b1;
                if (count_down()) begin
                    seq_phase = PH_RST_REL;
                    tick_cnt  = timed_ticks(10'(rst_rel_cfg));
                end
            end
            PH_RST_REL: begin
                if (count_down()) begin
                    seq_phase = PH_PRES_HI;
                    tick_cnt  = '0;
                    poll_cnt  = '0;
                end
            end
            PH_PRES_HI: begin
                if (tick_cnt != 0) begin
                    tick_cnt = tick_cnt - 16'd1;
                end else if (poll_cnt >= poll_lim_cfg) begin
                    err_flag = 1'b1;
                    start_write_byte();
                end else if (line) begin
                    poll_cnt = poll_cnt + 8'd1;
                    tick_cnt = timed_ticks(ONE_UNIT) - 16'd1;
                end else begin
                    seq_phase = PH_PRES_LO;
                    poll_cnt  = '0;
                    presence_low(line);
                end
            end
            PH_PRES_LO: begin
                if (tick_cnt != 0) begin
                    tick_cnt = tick_cnt - 16'd1;
                end else begin
                    presence_low(line);
                end
            end
            PH_WR_LOW: begin
                drv = 1'b1;
                if (count_down()) begin
                    seq_phase = PH_WR_REL;
                    tick_cnt  = timed_ticks(shreg[0] ? 10'(slot_cfg) : SHORT_UNITS);
                end
            end
            PH_WR_REL: begin
                if (count_down()) begin
                    shreg   = shreg >> 1;
                    bit_idx = bit_idx + 3'd1;
                    if (bit_idx != 0) begin
                        start_write_bit();
                    end else if (byte_idx == 2'd1) begin
                        byte_idx = 2'd2;
                        start_reset();
                    end else if (byte_idx == 2'd3) begin
                        byte_idx = 2'd0;
                        shreg    = '0;
                        start_read_bit();
                    end else begin
                        byte_idx = byte_idx + 2'd1;
                        start_write_byte();
                    end
                end
            end
            PH_RD_LOW: begin
                drv = 1'b1;
                if (count_down()) begin
                    seq_phase = PH_RD_SAMP;
                    tick_cnt  = 16'd1;
                end
            end
            PH_RD_SAMP: begin
                shreg     = {line, shreg[7:1]};
                seq_phase = PH_RD_REC;
                tick_cnt  = timed_ticks(10'(rec_cfg));
            end
            PH_RD_REC: begin
                if (count_down()) begin
                    bit_idx = bit_idx + 3'd1;
                    if (bit_idx != 0) begin
                        start_read_bit();
                    end else if (byte_idx == 2'd0) begin
                        lsb_byte = shreg;
                        byte_idx = 2'd1;
                        shreg    = '0;
                        start_read_bit();
                    end else begin
                        raw = {shreg, lsb_byte};
                        if (raw[15:11] == NEG_MASK) begin
                            temp_sign = 1'b1;
                            temp_mag  = ~raw + 16'd1;
                        end else begin
                            temp_sign = 1'b0;
                            temp_mag  = raw;
                        end
                        done      = 1'b1;
                        byte_idx  = 2'd0;
                        seq_phase = PH_IDLE;
                    end
                end
            end
            default: begin
                busy = 1'b0;
            end
        endcase
        return '{drv, busy, done, err_flag, temp_sign, temp_mag};
    endfunction

    // emulated sensor: presence pulse after hi_polls, released after lo_polls
    function automatic logic sensor_line(input logic [15:0] raw, input int hi_polls,
                                         input int lo_polls, input bit noisy);
        if (noisy) return 1'($urandom);
        case (seq_phase)
            PH_PRES_HI: return poll_cnt < hi_polls;
            PH_PRES_LO: return poll_cnt >= lo_polls;
            PH_RD_SAMP: return raw[{byte_idx[0], bit_idx}];
            default:    return 1'b1;
        endcase
    endfunction

    function automatic bit at_done_tick();
        return seq_phase == PH_RD_REC && byte_idx == 2'd1 && bit_idx == 3'd7
               && tick_cnt <= 16'd1;
    endfunction

    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t %s expected %0d actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic send_tick(input logic start, input logic line);
        int gap;
        item_if.valid         <= 1'b1;
        item_if.start_request <= start;
        item_if.line_level    <= line;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        pending_status.push_back(predict_tick(start, line));
        gap = idle_gap();
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_idle(input int n);
        repeat (n) send_tick(1'b0, 1'($urandom));
    endtask

    task automatic run_read(input logic [15:0] raw, input int hi_polls, input int lo_polls,
                            input bit busy_starts, input bit noisy);
        logic st;
        logic ln;
        send_tick(1'b1, 1'($urandom));
        while (seq_phase != PH_IDLE) begin
            ln = sensor_line(raw, hi_polls, lo_polls, noisy);
            st = busy_starts && ($urandom_range(0, 3) == 0 || at_done_tick());
            send_tick(st, ln);
        end
    endtask

    // start a read and stop sending after n ticks, the sequence left running
    task automatic run_partial(input logic [15:0] raw, input int hi_polls,
                               input int lo_polls, input int n);
        int k;
        send_tick(1'b1, 1'($urandom));
        for (k = 1; k < n && seq_phase != PH_IDLE; k++) begin
            send_tick(1'b0, sensor_line(raw, hi_polls, lo_polls, 1'b0));
        end
    endtask

    task automatic drain();
        item_if.valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            REG_TICKS_PER_UNIT: tpu_cfg      = data[7:0];
            REG_RESET_LOW:      rst_low_cfg  = data[9:0];
            REG_RESET_RELEASE:  rst_rel_cfg  = data[7:0];
            REG_POLL_LIMIT:     poll_lim_cfg = data[7:0];
            REG_WRITE_SLOT:     slot_cfg     = data[7:0];
            REG_READ_RECOVERY:  rec_cfg      = data[7:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_timing(input int tpu, input int rl, input int rr,
                              input int pl, input int ws, input int rc);
        cfg_write(REG_TICKS_PER_UNIT, 10'(tpu));
        cfg_write(REG_RESET_LOW, 10'(rl));
        cfg_write(REG_RESET_RELEASE, 10'(rr));
        cfg_write(REG_POLL_LIMIT, 10'(pl));
        cfg_write(REG_WRITE_SLOT, 10'(ws));
        cfg_write(REG_READ_RECOVERY, 10'(rc));
        cfg_we <= 1'b0;
    endtask

    task automatic test_default_timing();
        send_idle(4);
        // reset pulse, presence and the first write slots at reset timing
        run_partial(16'h0191, 3, 4, 100);
        drain();
        set_timing(0, 1, 0, 2, 1, 0);
        run_read(16'h0191, 3, 4, 1'b0, 1'b0);
        send_idle(3);
        drain();
    endtask

    task automatic test_fast_edges();
        // high bits beyond the register width and unused indexes
        cfg_write(REG_UNUSED_LO, 10'h3FF);
        cfg_write(REG_UNUSED_HI, 10'h155);
        cfg_write(REG_TICKS_PER_UNIT, 10'h300);
        cfg_write(REG_POLL_LIMIT, 10'h301);
        cfg_write(REG_WRITE_SLOT, 10'h3FF);
        cfg_write(REG_READ_RECOVERY, 10'h305);
        cfg_we <= 1'b0;
        // presence timeout while the line stays low
        run_read(16'hF800, 0, 255, 1'b0, 1'b0);
        drain();
    endtask

    task automatic test_zero_settings();
        set_timing(0, 0, 0, 0, 0, 0);
        run_read(16'hF7FF, 0, 0, 1'b1, 1'b0);
        drain();
    endtask

    task automatic test_result_stall();
        long_hold_req = 1'b1;
        wait (long_hold_req == 1'b0);
        send_idle(30);
        drain();
    endtask

    // result checker
    always @(posedge i_clk) begin : check_result
        t_result want;
        if (i_rst_n && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
            if (pending_status.size() == 0) begin
                $display("%0t unexpected item expected none actual %0d", $time,
                         result_if.temp_magnitude);
                fail_count++;
            end else begin
                want = pending_status.pop_front();
                compare_field("drive_low", want.drive_low, result_if.drive_low);
                compare_field("busy_res", want.busy_res, result_if.busy_res);
                compare_field("done_res", want.done_res, result_if.done_res);
                compare_field("presence_error", want.presence_error,
                              result_if.presence_error);
                compare_field("temp_negative", want.temp_negative, result_if.temp_negative);
                compare_field("temp_magnitude", want.temp_magnitude,
                              result_if.temp_magnitude);
            end
        end
    end

    // result side ready, with random stalls and one long hold-off
    initial begin : result_ready
        int stall;
        result_if.ready = 1'b0;
        @(posedge i_clk iff i_rst_n === 1'b1);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall = LONG_HOLD;
            end else begin
                stall = idle_gap();
            end
            if (stall > 0) begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_if.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        i_clk                 = 1'b0;
        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_idx               = '0;
        cfg_data              = '0;
        item_if.valid         = 1'b0;
        item_if.start_request = 1'b0;
        item_if.line_level    = 1'b1;
        fail_count            = 0;
        long_hold_req         = 1'b0;
        clear_state();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_timing();
        test_fast_edges();
        test_zero_settings();
        test_result_stall();

        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/owtr_pkg.sv
rtl/owtr_in_if.sv
rtl/owtr_out_if.sv
rtl/owtr_cfg.sv
rtl/owtr_core.sv
rtl/one_wire_temp_reader_top.sv
sim/one_wire_temp_reader_top_tb.sv
